// ----- src/pfa_pkg.sv -----
package pfa_pkg;

    localparam int STACK_DEPTH_DEF = 2048;
    localparam int PAGE_SHIFT_DEF  = 12;

    localparam int ACT_W       = 2;
    localparam int AMT_W       = 40;
    localparam int ADDR_W      = 64;
    localparam int FREE_W      = 41;
    localparam int ALLOC_W     = 40;
    localparam int TOTAL_W     = 41;
    localparam int LIM_W       = 53;
    localparam int CUR_W       = 54;
    localparam int CFG_DW      = 64;
    localparam int CFG_AW      = 5;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 192;

    typedef logic [ACT_W-1:0] t_action;
    localparam t_action ACT_ALLOC_PAGES = 2'd0;
    localparam t_action ACT_RELEASE     = 2'd1;
    localparam t_action ACT_ALLOC_BYTES = 2'd2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ENABLE       = 2'd0;
    localparam t_reg_idx REG_REGION_BASE  = 2'd1;
    localparam t_reg_idx REG_REGION_LIMIT = 2'd2;
    localparam t_reg_idx REG_MAP_OFFSET   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_POP_CHK,
        ST_ALIGN,
        ST_ROOM,
        ST_BUMP,
        ST_REL_SUB,
        ST_REL_FRAME,
        ST_REL_CLAMP,
        ST_WALK,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_PUSH,
        ST_TAIL_RD,
        ST_TAIL_CMP,
        ST_TAIL_SUB,
        ST_FIN_CALC,
        ST_FIN_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_DECODE,
        OP_POP_RD,
        OP_POP_CHK,
        OP_ALIGN,
        OP_ROOM,
        OP_BUMP,
        OP_REL_SUB,
        OP_REL_FRAME,
        OP_REL_CLAMP,
        OP_WALK,
        OP_SRCH_RD,
        OP_SRCH_CMP,
        OP_PUSH,
        OP_TAIL_RD,
        OP_TAIL_CMP,
        OP_TAIL_SUB,
        OP_FIN_CALC,
        OP_LOAD
    } t_op;

    typedef struct packed {
        logic dec_fail;
        logic is_pop;
        logic is_rel;
        logic cnt_zero;
        logic pop_hit;
        logic bump_fail;
        logic rel_bad;
        logic more;
        logic room;
        logic match;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ----- src/page_frame_allocator_core.sv -----
// Page frame allocator over one physical region.
// Request channel (s_*): tuser carries the action (allocate pages, release
// pages, allocate bytes), tdata the amount and the virtual start address of a
// release. Every request yields exactly one result on the m_* channel: ok in
// tuser, and in tdata the virtual address and the free, allocated and total
// page counts after the request.
// Registers are written over the APB port; the user must write them only while
// the block is idle, and the block itself does not enforce this. Writing 1 to
// enable empties the released-page stack, zeroes the allocated count and sets
// the cursor to the aligned region base. One request is handled at a time.
// For each page walked, a release searches the stacked frames through the
// single read port of the stack memory; with the stack full, the stacked
// frames are scanned for the rest of the range. The result sits in an output
// register: a new request is taken while it waits, and the next result is
// held back until the receiver takes the previous one. Reset (synchronous)
// leaves the block disabled.
module page_frame_allocator_core import pfa_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // amount, start_address
    input  logic [ACT_W-1:0]       i_s_tuser,   // action
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // address, free_pages, allocated_pages, total_pages
    output logic                   o_m_tuser,   // ok
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [CFG_AW-1:0]      i_paddr,
    input  logic [CFG_DW-1:0]      i_pwdata,
    output logic [CFG_DW-1:0]      o_prdata,
    output logic                   o_pready
);

    localparam int HF_W = CUR_W - PAGE_SHIFT;
    localparam logic [CUR_W-1:0] CUR_MASK = {{(CUR_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

    logic               r_enable;
    logic [LIM_W-1:0]   r_base;
    logic [CUR_W-1:0]   r_base_al;
    logic [LIM_W-1:0]   r_limit;
    logic [HF_W-1:0]    r_hi_f;
    logic [ADDR_W-1:0]  r_offset;

    logic               w_wr;
    logic               w_init;
    t_reg_idx           w_idx;
    logic [CUR_W-1:0]   w_wd_al;
    logic [CUR_W-1:0]   w_wd_up;
    t_op                w_op;
    t_stat              w_stat;

    logic               w_ok;
    logic [ADDR_W-1:0]  w_address;
    logic [FREE_W-1:0]  w_free;
    logic [ALLOC_W-1:0] w_alloc;
    logic [TOTAL_W-1:0] w_total;

    assign o_pready = 1'b1;
    assign w_idx    = i_paddr[CFG_AW-1:3];
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_init   = w_wr && (w_idx == REG_ENABLE) && i_pwdata[0];
    assign w_wd_up  = CUR_W'(i_pwdata[LIM_W-1:0]) + CUR_MASK;
    assign w_wd_al  = w_wd_up & ~CUR_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_base    <= '0;
            r_base_al <= '0;
            r_limit   <= '0;
            r_hi_f    <= '0;
            r_offset  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_ENABLE:      r_enable <= i_pwdata[0];
                REG_REGION_BASE: begin
                    r_base    <= i_pwdata[LIM_W-1:0];
                    r_base_al <= w_wd_al;
                end
                REG_REGION_LIMIT: begin
                    r_limit <= i_pwdata[LIM_W-1:0];
                    r_hi_f  <= w_wd_up[CUR_W-1:PAGE_SHIFT];
                end
                REG_MAP_OFFSET:  r_offset <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ENABLE:       o_prdata = CFG_DW'(r_enable);
            REG_REGION_BASE:  o_prdata = CFG_DW'(r_base);
            REG_REGION_LIMIT: o_prdata = CFG_DW'(r_limit);
            REG_MAP_OFFSET:   o_prdata = r_offset;
            default:          o_prdata = '0;
        endcase
    end

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_op       (w_op)
    );

    pfa_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (w_op),
        .o_stat            (w_stat),
        .i_action          (i_s_tuser),
        .i_amount          (i_s_tdata[AMT_W-1:0]),
        .i_start_address   (i_s_tdata[AMT_W +: ADDR_W]),
        .i_enable          (r_enable),
        .i_init            (w_init),
        .i_base_al         (r_base_al),
        .i_limit           (r_limit),
        .i_hi_f            (r_hi_f),
        .i_offset          (r_offset),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_ok              (w_ok),
        .o_address         (w_address),
        .o_free_pages      (w_free),
        .o_allocated_pages (w_alloc),
        .o_total_pages     (w_total)
    );

    assign o_m_tuser = w_ok;
    assign o_m_tdata = {{(OUT_TDATA_W-ADDR_W-FREE_W-ALLOC_W-TOTAL_W){1'b0}},
                        w_total, w_alloc, w_free, w_address};

endmodule

// ----- src/pfa_ram.sv -----
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pfa_ctrl.sv -----
module pfa_ctrl import pfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_op   o_op
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_s_tvalid) n_state = ST_DECODE;
            ST_DECODE: begin
                if (i_stat.dec_fail)     n_state = ST_FIN_CALC;
                else if (i_stat.is_pop)  n_state = ST_POP;
                else if (i_stat.is_rel)  n_state = ST_REL_SUB;
                else                     n_state = ST_ALIGN;
            end
            ST_POP:       n_state = i_stat.cnt_zero ? ST_ALIGN : ST_POP_CHK;
            ST_POP_CHK:   n_state = i_stat.pop_hit ? ST_FIN_CALC : ST_POP;
            ST_ALIGN:     n_state = ST_ROOM;
            ST_ROOM:      n_state = ST_BUMP;
            ST_BUMP:      n_state = ST_FIN_CALC;
            ST_REL_SUB:   n_state = ST_REL_FRAME;
            ST_REL_FRAME: n_state = i_stat.rel_bad ? ST_FIN_CALC : ST_REL_CLAMP;
            ST_REL_CLAMP: n_state = ST_WALK;
            ST_WALK: begin
                if (!i_stat.more)         n_state = ST_FIN_CALC;
                else if (!i_stat.room)    n_state = ST_TAIL_RD;
                else if (i_stat.cnt_zero) n_state = ST_PUSH;
                else                      n_state = ST_SRCH_RD;
            end
            ST_SRCH_RD:   n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (i_stat.match)        n_state = ST_WALK;
                else if (i_stat.last)    n_state = ST_PUSH;
                else                     n_state = ST_SRCH_RD;
            end
            ST_PUSH:      n_state = ST_WALK;
            ST_TAIL_RD:   n_state = ST_TAIL_CMP;
            ST_TAIL_CMP:  n_state = i_stat.last ? ST_TAIL_SUB : ST_TAIL_RD;
            ST_TAIL_SUB:  n_state = ST_FIN_CALC;
            ST_FIN_CALC:  n_state = ST_FIN_OUT;
            ST_FIN_OUT:   if (i_stat.out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_op       = OP_NONE;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) o_op = OP_CAPTURE;
            end
            ST_DECODE:    o_op = OP_DECODE;
            ST_POP:       o_op = i_stat.cnt_zero ? OP_NONE : OP_POP_RD;
            ST_POP_CHK:   o_op = OP_POP_CHK;
            ST_ALIGN:     o_op = OP_ALIGN;
            ST_ROOM:      o_op = OP_ROOM;
            ST_BUMP:      o_op = OP_BUMP;
            ST_REL_SUB:   o_op = OP_REL_SUB;
            ST_REL_FRAME: o_op = i_stat.rel_bad ? OP_NONE : OP_REL_FRAME;
            ST_REL_CLAMP: o_op = OP_REL_CLAMP;
            ST_WALK:      o_op = OP_WALK;
            ST_SRCH_RD:   o_op = OP_SRCH_RD;
            ST_SRCH_CMP:  o_op = OP_SRCH_CMP;
            ST_PUSH:      o_op = OP_PUSH;
            ST_TAIL_RD:   o_op = OP_TAIL_RD;
            ST_TAIL_CMP:  o_op = OP_TAIL_CMP;
            ST_TAIL_SUB:  o_op = OP_TAIL_SUB;
            ST_FIN_CALC:  o_op = OP_FIN_CALC;
            ST_FIN_OUT:   o_op = i_stat.out_free ? OP_LOAD : OP_NONE;
            default:      o_op = OP_NONE;
        endcase
    end

endmodule

// ----- src/pfa_dp.sv -----
module pfa_dp import pfa_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF,
    localparam int HF_W = CUR_W - PAGE_SHIFT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op                i_op,
    output t_stat              o_stat,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [AMT_W-1:0]   i_amount,
    input  logic [ADDR_W-1:0]  i_start_address,
    input  logic               i_enable,
    input  logic               i_init,
    input  logic [CUR_W-1:0]   i_base_al,
    input  logic [LIM_W-1:0]   i_limit,
    input  logic [HF_W-1:0]    i_hi_f,
    input  logic [ADDR_W-1:0]  i_offset,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic               o_ok,
    output logic [ADDR_W-1:0]  o_address,
    output logic [FREE_W-1:0]  o_free_pages,
    output logic [ALLOC_W-1:0] o_allocated_pages,
    output logic [TOTAL_W-1:0] o_total_pages
);

    localparam int FRAME_W = LIM_W - PAGE_SHIFT;
    localparam int FN_W    = ADDR_W - PAGE_SHIFT + 1;
    localparam int NEED_W  = AMT_W + PAGE_SHIFT;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int RAM_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CMP_W   = (NEED_W > CUR_W) ? NEED_W : CUR_W;
    localparam int SUM_W   = ((HF_W > FREE_W) ? HF_W : FREE_W) + 1;

    localparam logic [CUR_W-1:0]   CUR_MASK  = {{(CUR_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    localparam logic [NEED_W:0]    NEED_MASK = {{(NEED_W+1-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    localparam logic [NEED_W-1:0]  PAGE_BYTES = {{(NEED_W-PAGE_SHIFT-1){1'b0}}, 1'b1, {PAGE_SHIFT{1'b0}}};
    localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(STACK_DEPTH);
    localparam logic [SUM_W-1:0]   FREE_MAX  = SUM_W'({FREE_W{1'b1}});

    // command capture and working registers
    logic [ACT_W-1:0]   r_act;
    logic [AMT_W-1:0]   r_amt;
    logic [ADDR_W-1:0]  r_va;
    logic               r_ok;
    logic               r_has_addr;
    logic [CUR_W-1:0]   r_phys;
    logic [NEED_W-1:0]  r_need;
    logic [ALLOC_W-1:0] r_pages;
    logic [CUR_W-1:0]   r_start;
    logic [CUR_W-1:0]   r_room;
    logic               r_start_bad;
    logic [ADDR_W-1:0]  r_rphys;
    logic               r_rbad;
    logic [FN_W-1:0]    r_f;
    logic [FN_W-1:0]    r_end;
    logic [FN_W-1:0]    r_rest;
    logic [CNT_W-1:0]   r_i;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_below;
    logic [HF_W-1:0]    r_lin;
    logic [HF_W-1:0]    r_tot;

    // allocator state
    logic [CUR_W-1:0]   r_cursor;
    logic [ALLOC_W-1:0] r_alloc;
    logic [CNT_W-1:0]   r_cnt;

    // result register
    logic               r_o_valid;
    logic               r_o_ok;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [FREE_W-1:0]  r_o_free;
    logic [ALLOC_W-1:0] r_o_alloc;
    logic [TOTAL_W-1:0] r_o_tot;

    logic [FRAME_W-1:0] w_rdata;
    logic [RAM_AW-1:0]  w_raddr;
    logic               w_we;
    logic [CNT_W-1:0]   w_cnt_m1;
    logic [HF_W-1:0]    w_lo_f;
    logic [HF_W-1:0]    w_fr_ext;
    logic [AMT_W:0]     w_bytes16;
    logic [NEED_W-1:0]  w_need_bytes;
    logic [NEED_W:0]    w_pg_sum;
    logic [ADDR_W:0]    w_rdiff;
    logic [CUR_W-1:0]   w_lim_ext;
    logic [CUR_W-1:0]   w_lc_diff;
    logic [CUR_W-1:0]   w_lb_diff;
    logic [SUM_W-1:0]   w_free_sum;
    logic               w_out_free;

    function automatic logic [ALLOC_W-1:0] sat_add(input logic [ALLOC_W-1:0] a,
                                                   input logic [ALLOC_W-1:0] b);
        logic [ALLOC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ALLOC_W] ? {ALLOC_W{1'b1}} : s[ALLOC_W-1:0];
    endfunction

    function automatic logic [ALLOC_W-1:0] sat_sub(input logic [ALLOC_W-1:0] a,
                                                   input logic [FN_W-1:0] b);
        logic [FN_W-1:0] ae;
        ae = FN_W'(a);
        return (b > ae) ? '0 : (a - b[ALLOC_W-1:0]);
    endfunction

    assign w_cnt_m1   = r_cnt - CNT_W'(1);
    assign w_lo_f     = i_base_al[CUR_W-1:PAGE_SHIFT];
    assign w_fr_ext   = HF_W'(w_rdata);
    assign w_lim_ext  = CUR_W'(i_limit);
    assign w_bytes16  = ({1'b0, r_amt} + (AMT_W+1)'(15)) & ~(AMT_W+1)'(15);
    assign w_need_bytes = (NEED_W'(w_bytes16) < PAGE_BYTES) ? PAGE_BYTES : NEED_W'(w_bytes16);
    assign w_pg_sum   = {1'b0, r_need} + NEED_MASK;
    assign w_rdiff    = {1'b0, r_va} - {1'b0, i_offset};
    assign w_lc_diff  = w_lim_ext - r_cursor;
    assign w_lb_diff  = w_lim_ext - i_base_al;
    assign w_free_sum = SUM_W'(r_lin) + SUM_W'(r_cnt);
    assign w_out_free = !r_o_valid || i_m_tready;

    assign w_raddr = (i_op == OP_POP_RD) ? w_cnt_m1[RAM_AW-1:0] : r_i[RAM_AW-1:0];
    assign w_we    = (i_op == OP_PUSH);

    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[RAM_AW-1:0]),
        .i_wdata (r_f[FRAME_W-1:0]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_stat.dec_fail  = !i_enable || (r_amt == '0) ||
                           !(r_act == ACT_ALLOC_PAGES || r_act == ACT_RELEASE ||
                             r_act == ACT_ALLOC_BYTES);
        o_stat.is_pop    = (r_act == ACT_ALLOC_PAGES) && (r_amt == AMT_W'(1));
        o_stat.is_rel    = (r_act == ACT_RELEASE);
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.pop_hit   = (w_fr_ext >= w_lo_f) && (w_fr_ext < i_hi_f);
        o_stat.bump_fail = r_start_bad || (CMP_W'(r_need) > CMP_W'(r_room));
        o_stat.rel_bad   = r_rbad || (r_rphys[PAGE_SHIFT-1:0] != '0);
        o_stat.more      = (r_f < r_end);
        o_stat.room      = (r_cnt < DEPTH_C);
        o_stat.match     = (w_rdata == r_f[FRAME_W-1:0]);
        o_stat.last      = (r_i == w_cnt_m1);
        o_stat.out_free  = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_alloc   <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_op == OP_LOAD) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_init) begin
                r_cursor <= i_base_al;
                r_alloc  <= '0;
                r_cnt    <= '0;
            end
            case (i_op)
                OP_POP_RD: r_cnt <= w_cnt_m1;
                OP_POP_CHK: begin
                    if (o_stat.pop_hit) r_alloc <= sat_add(r_alloc, ALLOC_W'(1));
                end
                OP_BUMP: begin
                    if (!o_stat.bump_fail) begin
                        r_cursor <= r_start + CUR_W'(r_need);
                        r_alloc  <= sat_add(r_alloc, r_pages);
                    end
                end
                OP_PUSH: begin
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_alloc <= sat_sub(r_alloc, FN_W'(1));
                end
                OP_TAIL_SUB: r_alloc <= sat_sub(r_alloc, r_rest);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_CAPTURE: begin
                r_act      <= i_action;
                r_amt      <= i_amount;
                r_va       <= i_start_address;
                r_ok       <= 1'b0;
                r_has_addr <= 1'b0;
            end
            OP_DECODE: begin
                r_need <= (r_act == ACT_ALLOC_BYTES) ? w_need_bytes
                                                     : {r_amt, {PAGE_SHIFT{1'b0}}};
            end
            OP_POP_CHK: begin
                if (o_stat.pop_hit) begin
                    r_phys     <= CUR_W'({w_rdata, {PAGE_SHIFT{1'b0}}});
                    r_ok       <= 1'b1;
                    r_has_addr <= 1'b1;
                end
            end
            OP_ALIGN: begin
                r_start <= (r_cursor + CUR_MASK) & ~CUR_MASK;
                r_pages <= (r_act == ACT_ALLOC_BYTES) ? w_pg_sum[PAGE_SHIFT +: ALLOC_W] : r_amt;
            end
            OP_ROOM: begin
                r_start_bad <= (r_start >= w_lim_ext);
                r_room      <= w_lim_ext - r_start;
            end
            OP_BUMP: begin
                if (!o_stat.bump_fail) begin
                    r_phys     <= r_start;
                    r_ok       <= 1'b1;
                    r_has_addr <= 1'b1;
                end
            end
            OP_REL_SUB: begin
                // borrow out means start address below the map offset
                r_rbad  <= (r_va == '0) || w_rdiff[ADDR_W];
                r_rphys <= w_rdiff[ADDR_W-1:0];
            end
            OP_REL_FRAME: begin
                r_f   <= FN_W'(r_rphys[ADDR_W-1:PAGE_SHIFT]);
                r_end <= FN_W'(r_rphys[ADDR_W-1:PAGE_SHIFT]) + FN_W'(r_amt);
            end
            OP_REL_CLAMP: begin
                if (r_end > FN_W'(i_hi_f)) r_end <= FN_W'(i_hi_f);
                if (r_f < FN_W'(w_lo_f))   r_f   <= FN_W'(w_lo_f);
                r_ok <= 1'b1;
            end
            OP_WALK: begin
                r_i    <= '0;
                r_rest <= r_end - r_f;
            end
            OP_SRCH_CMP: begin
                if (o_stat.match) r_f <= r_f + FN_W'(1);
                else              r_i <= r_i + CNT_W'(1);
            end
            OP_PUSH: r_f <= r_f + FN_W'(1);
            OP_TAIL_CMP: begin
                if (FN_W'(w_rdata) >= r_f && FN_W'(w_rdata) < r_end) begin
                    r_rest <= r_rest - FN_W'(1);
                end
                r_i <= r_i + CNT_W'(1);
            end
            OP_FIN_CALC: begin
                r_addr  <= r_has_addr ? (ADDR_W'(r_phys) + i_offset) : '0;
                r_below <= (r_cursor < i_base_al);
                r_lin   <= (w_lim_ext > r_cursor) ? w_lc_diff[CUR_W-1:PAGE_SHIFT] : '0;
                r_tot   <= (w_lim_ext > i_base_al) ? w_lb_diff[CUR_W-1:PAGE_SHIFT] : '0;
            end
            OP_LOAD: begin
                r_o_ok    <= r_ok;
                r_o_addr  <= r_addr;
                r_o_alloc <= r_alloc;
                if (!i_enable || r_below)    r_o_free <= '0;
                else if (w_free_sum > FREE_MAX) r_o_free <= {FREE_W{1'b1}};
                else                         r_o_free <= w_free_sum[FREE_W-1:0];
                r_o_tot <= (SUM_W'(r_tot) > FREE_MAX) ? {TOTAL_W{1'b1}}
                                                       : TOTAL_W'(SUM_W'(r_tot));
            end
            default: ;
        endcase
    end

    assign o_m_tvalid        = r_o_valid;
    assign o_ok              = r_o_ok;
    assign o_address         = r_o_addr;
    assign o_free_pages      = r_o_free;
    assign o_allocated_pages = r_o_alloc;
    assign o_total_pages     = r_o_tot;

endmodule

// ----- src/pfa_checker.sv -----
module pfa_checker import pfa_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser
);

    // result held while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not empty after reset");

    // one request in flight at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request taken while busy");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[ADDR_W-1:0] == '0)
        else $error("failed result carries an address");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);
